// ----- rtl/weighted_pick_with_quotas_defines.svh -----
// Assertion macros shared by the weighted pick block.
`ifndef WEIGHTED_PICK_WITH_QUOTAS_DEFINES_SVH
`define WEIGHTED_PICK_WITH_QUOTAS_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define WPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wpq_pkg.sv -----
// Types and constants of the weighted pick block.
`timescale 1ns / 1ps

package wpq_pkg;

    localparam int CFG_W      = 5;
    localparam int OP_W       = 2;
    localparam int SLOT_W     = 4;
    localparam int ID_W       = 8;
    localparam int WEIGHT_W   = 8;
    localparam int LIMIT_W    = 8;
    localparam int RV_W       = 16;
    localparam int STATUS_W   = 2;
    localparam int REM_W      = 12;
    localparam int WEIGHT_MAX = (1 << WEIGHT_W) - 1;

    localparam logic [REM_W-1:0] REM_MAX = '1;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [SLOT_W-1:0]   entry_index;
        logic [ID_W-1:0]     entry_id;
        logic [WEIGHT_W-1:0] weight;
        logic [LIMIT_W-1:0]  use_limit;
        logic [RV_W-1:0]     random_value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     chosen_id;
        logic [SLOT_W-1:0]   chosen_index;
        logic [REM_W-1:0]    remaining_weight;
    } out_item_t;

    // One memory word: id, weight and a count (use limit or uses left).
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
        logic [LIMIT_W-1:0]  count;
    } entry_word_t;

endpackage

// ----- rtl/weighted_pick_with_quotas.sv -----
// Weighted random pick over a table of entries with per-entry use quotas.
// A restart copies the first n table slots into the draw set (n is the register clamped to MAX_ENTRIES).
// A draw that needs a pick reaches its result by the scan of the draw-set memory one entry
// per cycle; the next item follows the result.
// A finished result waits in the output register while the next item is taken.
// Reset clears the active mask, total weight and register; the table is undefined until written.
`timescale 1ns / 1ps

`include "weighted_pick_with_quotas_defines.svh"

module weighted_pick_with_quotas #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [wpq_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  wpq_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output wpq_pkg::out_item_t         out_data
);

    import wpq_pkg::*;

    // Widths that follow from the table depth.
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int TOT_W = $clog2(MAX_ENTRIES * WEIGHT_MAX + 1);
    localparam int PW    = RV_W + TOT_W;
    localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // Sequencer codes.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RESTART = 3'd1;
    localparam logic [2:0] S_MUL     = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    // Saturate the running total to the width of the result field.
    function automatic logic [REM_W-1:0] sat_total(input logic [TOT_W-1:0] t);
        if (32'(t) > 32'(REM_MAX))
            return REM_MAX;
        else
            return REM_W'(t);
    endfunction

    // Loaded table and draw set: two synchronous memories, registered read.
    entry_word_t tbl_mem  [MAX_ENTRIES];
    entry_word_t live_mem [MAX_ENTRIES];
    entry_word_t tbl_rd_reg;
    entry_word_t live_rd_reg;

    logic [2:0]          state_reg,     state_next;
    logic [CNT_W-1:0]    ptr_reg,       ptr_next;
    logic [CNT_W-1:0]    n_reg,         n_next;
    logic                rd_valid_reg,  rd_valid_next;
    logic [IDX_W-1:0]    rd_addr_reg,   rd_addr_next;
    logic [TOT_W-1:0]    pick_reg,      pick_next;
    logic [RV_W-1:0]     rv_reg,        rv_next;
    logic [TOT_W-1:0]    total_reg,     total_next;
    logic [MAX_ENTRIES-1:0] active_reg, active_next;
    logic [CFG_W-1:0]    eiu_reg,       eiu_next;
    out_item_t           res_reg,       res_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg,  out_data_next;

    // Memory port controls.
    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_waddr;
    entry_word_t         tbl_wdata;
    logic                rd_en;
    logic                live_we;
    logic [IDX_W-1:0]    live_waddr;
    entry_word_t         live_wdata;

    // Datapath helpers.
    logic [NW-1:0]       cfg_wide;
    logic [CNT_W-1:0]    clamp_n;
    logic [PW-1:0]       prod;
    logic [TOT_W-1:0]    live_w;
    logic                hit;
    logic                use_out;
    logic [TOT_W-1:0]    total_after;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the entry count to the table depth.
    assign cfg_wide = NW'(eiu_reg);
    assign clamp_n  = (cfg_wide > NW'(MAX_ENTRIES)) ? MAX_CNT : CNT_W'(cfg_wide);

    // Scale the random value into [0, total).
    assign prod = PW'(rv_reg) * PW'(total_reg);

    // Scan compare on the entry read last cycle.
    assign live_w      = TOT_W'(live_rd_reg.weight);
    assign hit         = (pick_reg < live_w);
    assign use_out     = (live_rd_reg.count == LIMIT_W'(1));
    assign total_after = use_out ? ((total_reg >= live_w) ? (total_reg - live_w) : '0)
                                 : total_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        n_next         = n_reg;
        rd_valid_next  = 1'b0;
        rd_addr_next   = rd_addr_reg;
        pick_next      = pick_reg;
        rv_next        = rv_reg;
        total_next     = total_reg;
        active_next    = active_reg;
        eiu_next       = eiu_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        tbl_we     = 1'b0;
        tbl_waddr  = IDX_W'(in_data.entry_index);
        tbl_wdata  = '{id: in_data.entry_id, weight: in_data.weight, count: in_data.use_limit};
        rd_en      = 1'b0;
        live_we    = 1'b0;
        live_waddr = rd_addr_reg;
        live_wdata = tbl_rd_reg;

        // Drop the output once the sink takes the transfer.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // Take a register write at any time; an item in flight already holds its count.
        if (cfg_valid)
            eiu_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.opcode)
                        OP_WRITE:
                        begin
                            // Ignore slots beyond the table.
                            if (int'(in_data.entry_index) < MAX_ENTRIES)
                                tbl_we = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            // Clear the draw set, then refill it slot by slot.
                            active_next = '0;
                            total_next  = '0;
                            ptr_next    = '0;
                            n_next      = clamp_n;
                            state_next  = S_RESTART;
                        end
                        OP_DRAW:
                        begin
                            if (eiu_reg == '0)
                            begin
                                res_next = '{status: ST_NONE, chosen_id: '0,
                                             chosen_index: '0,
                                             remaining_weight: sat_total(total_reg)};
                                state_next = S_DONE;
                            end
                            else if (total_reg == '0)
                            begin
                                res_next = '{status: ST_EXHAUSTED, chosen_id: '0,
                                             chosen_index: '0, remaining_weight: '0};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rv_next    = in_data.random_value;
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            // Unused opcode: no effect, no result.
                        end
                    endcase
                end
            end

            S_RESTART:
            begin
                // Issue one table read a cycle; copy the word in the next cycle.
                if (ptr_reg < n_reg)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    live_we                  = 1'b1;
                    active_next[rd_addr_reg] = 1'b1;
                    total_next = total_reg + TOT_W'(tbl_rd_reg.weight);
                end
                else if (ptr_reg == n_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_MUL:
            begin
                pick_next  = prod[PW-1:RV_W];
                ptr_next   = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // Read ahead one entry a cycle; test the entry read last cycle.
                if (ptr_reg < MAX_CNT)
                begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = ptr_reg[IDX_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                if (rd_valid_reg && active_reg[rd_addr_reg])
                begin
                    if (hit)
                    begin
                        // Spend one use; retire the entry when its quota runs out.
                        if (live_rd_reg.count != '0)
                        begin
                            live_we          = 1'b1;
                            live_wdata       = live_rd_reg;
                            live_wdata.count = live_rd_reg.count - LIMIT_W'(1);
                        end
                        if (use_out)
                            active_next[rd_addr_reg] = 1'b0;
                        total_next    = total_after;
                        res_next      = '{status: ST_OK, chosen_id: live_rd_reg.id,
                                          chosen_index: SLOT_W'(rd_addr_reg),
                                          remaining_weight: sat_total(total_after)};
                        rd_valid_next = 1'b0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        pick_next = pick_reg - live_w;
                    end
                end
                else if (!rd_valid_reg && ptr_reg == MAX_CNT)
                begin
                    res_next = '{status: ST_EXHAUSTED, chosen_id: '0,
                                 chosen_index: '0, remaining_weight: '0};
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Loaded table: written by write items, read by the restart sweep.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= tbl_wdata;
        if (rd_en)
            tbl_rd_reg <= tbl_mem[ptr_reg[IDX_W-1:0]];
    end

    // Draw set: written by the sweep and by write-back of a hit, read by the scan.
    // Write-back ends the scan, so a read never overlaps a pending write.
    always_ff @(posedge clk)
    begin
        if (live_we)
            live_mem[live_waddr] <= live_wdata;
        if (rd_en)
            live_rd_reg <= live_mem[ptr_reg[IDX_W-1:0]];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        pick_reg     <= pick_next;
        rv_reg       <= rv_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        n_reg        <= n_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            total_reg     <= '0;
            active_reg    <= '0;
            eiu_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            eiu_reg       <= eiu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `WPQ_ASSERT_NEXT(a_retire_on_last_use,
        (state_reg == S_SCAN && rd_valid_reg && active_reg[rd_addr_reg] && hit && use_out),
        (!active_reg[$past(rd_addr_reg)]), "entry still active after its last use")
    `WPQ_ASSERT_NOW(a_scan_ptr_range, (state_reg == S_SCAN), (ptr_reg <= MAX_CNT),
        "scan pointer beyond the table")
    `WPQ_ASSERT_NOW(a_no_pick_without_ok, (out_valid_reg && out_data_reg.status != ST_OK),
        (out_data_reg.chosen_id == '0 && out_data_reg.chosen_index == '0),
        "id or slot set on a result without a pick")
    `WPQ_ASSERT_NEXT(a_result_waits, (state_reg == S_DONE && out_valid_reg && !out_ready),
        (state_reg == S_DONE && $stable(out_data_reg)), "pending result overwritten")

endmodule

// ----- tb/weighted_pick_with_quotas_test.sv -----
// Self-checking testbench for the weighted pick block with per-entry use quotas.
`timescale 1ns / 1ps

module weighted_pick_with_quotas_test;

    import wpq_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 850;
    // A draw scans at most every slot; a restart is shorter.
    localparam int SETTLE       = 2 * SLOTS + 8;
    localparam int SHOWN_FAULTS = 10;

    // Opcode 3 has no meaning for the block: it must be dropped without a result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;

    weighted_pick_with_quotas #(
        .MAX_ENTRIES(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: the loaded table, the draw set built by the
    // last restart, the quotas left, and the register value.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]     tbl_id     [SLOTS] = '{default: '0};
    logic [WEIGHT_W-1:0] tbl_weight [SLOTS] = '{default: '0};
    logic [LIMIT_W-1:0]  tbl_limit  [SLOTS] = '{default: '0};
    logic [ID_W-1:0]     set_id     [SLOTS] = '{default: '0};
    logic [WEIGHT_W-1:0] set_weight [SLOTS] = '{default: '0};
    logic [LIMIT_W-1:0]  uses_left  [SLOTS] = '{default: '0};
    logic [SLOTS-1:0]    active_set = '0;
    int unsigned         active_total = 0;
    logic [CFG_W-1:0]    entries_cfg = '0;

    in_item_t  item_backlog[$];     // items waiting for the driver
    out_item_t expected_picks[$];   // draw results still owed by the block

    int  random_sent = 0;
    int  fault_count = 0;
    bit  no_idle = 1'b0;            // set for phases that run without gaps or stalls
    int  send_gap = 0;
    int  recv_stall = 0;
    out_item_t want;

    // Work out what one accepted item does to the shadow state and queue
    // the draw result it owes, if any.
    task automatic predict_pick(input in_item_t it);
        out_item_t        res;
        longint unsigned  pick;
        int unsigned      in_use;
        bit               hit;
        res = '0;
        hit = 1'b0;
        case (it.opcode)
            OP_WRITE: begin
                // The slot field cannot reach past SLOTS, so every write lands.
                tbl_id[it.entry_index]     = it.entry_id;
                tbl_weight[it.entry_index] = it.weight;
                tbl_limit[it.entry_index]  = it.use_limit;
            end
            OP_RESTART: begin
                // Clamp the register to the table size, then rebuild the draw set.
                in_use = (entries_cfg > SLOTS) ? SLOTS : entries_cfg;
                active_total = 0;
                for (int s = 0; s < SLOTS; s++) begin
                    active_set[s] = (s < in_use);
                    set_id[s]     = (s < in_use) ? tbl_id[s] : '0;
                    set_weight[s] = (s < in_use) ? tbl_weight[s] : '0;
                    uses_left[s]  = (s < in_use) ? tbl_limit[s] : '0;
                    if (s < in_use)
                        active_total += tbl_weight[s];
                end
            end
            OP_DRAW: begin
                if (entries_cfg == 0) begin
                    // Nothing configured: report the current total, no entry.
                    res.status = ST_NONE;
                    res.remaining_weight = (active_total > REM_MAX) ? REM_MAX
                                         : active_total[REM_W-1:0];
                end else begin
                    if (active_total != 0) begin
                        // Scale the random value into [0, total) and walk the spans.
                        pick = (longint'(it.random_value) * active_total) >> RV_W;
                        for (int s = 0; s < SLOTS && !hit; s++) begin
                            if (active_set[s]) begin
                                if (pick < set_weight[s]) begin
                                    hit = 1'b1;
                                    res.chosen_id    = set_id[s];
                                    res.chosen_index = s[SLOT_W-1:0];
                                    // A zero quota means unlimited: never retire it.
                                    if (uses_left[s] != 0) begin
                                        uses_left[s]--;
                                        if (uses_left[s] == 0) begin
                                            active_set[s] = 1'b0;
                                            active_total = (active_total >= set_weight[s])
                                                         ? active_total - set_weight[s] : 0;
                                        end
                                    end
                                    res.remaining_weight = (active_total > REM_MAX) ? REM_MAX
                                                         : active_total[REM_W-1:0];
                                end else begin
                                    pick -= set_weight[s];
                                end
                            end
                        end
                    end
                    if (!hit) begin
                        // Empty draw set or only zero weights left.
                        res = '0;
                        res.status = ST_EXHAUSTED;
                    end
                end
                expected_picks = {expected_picks, res};
            end
            default: ;
        endcase
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 93)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: present backlog items one transfer at a time, hold each
    // until accepted, and insert random gaps between them.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_pick(in_data);
                if (!no_idle && $urandom_range(0, 2) == 0)
                    send_gap = idle_cycles();
            end
            // Advance only when nothing is held or the held item just went through.
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (item_backlog.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= item_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the result channel at random and check every result
    // transfer against the oldest expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_picks.size() == 0) begin
                    note_fault($sformatf("unexpected result: status %0d id %0d index %0d weight %0d",
                        out_data.status, out_data.chosen_id, out_data.chosen_index,
                        out_data.remaining_weight));
                end else begin
                    want = expected_picks.pop_front();
                    if (out_data.status !== want.status
                        || out_data.chosen_id !== want.chosen_id
                        || out_data.chosen_index !== want.chosen_index
                        || out_data.remaining_weight !== want.remaining_weight)
                        note_fault($sformatf({"draw mismatch (expected/actual): status %0d/%0d ",
                            "id %0d/%0d index %0d/%0d weight %0d/%0d"},
                            want.status, out_data.status, want.chosen_id, out_data.chosen_id,
                            want.chosen_index, out_data.chosen_index,
                            want.remaining_weight, out_data.remaining_weight));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    recv_stall = idle_cycles();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Every field random, so unused fields toggle on every opcode too.
    function automatic in_item_t rand_item(input logic [OP_W-1:0] op);
        in_item_t it;
        it = '0;
        it.opcode       = op;
        it.entry_index  = SLOT_W'($urandom_range(0, SLOTS - 1));
        it.entry_id     = ID_W'($urandom_range(0, 255));
        it.weight       = WEIGHT_W'($urandom_range(0, 255));
        it.use_limit    = LIMIT_W'($urandom_range(0, 255));
        it.random_value = RV_W'($urandom_range(0, 16'hFFFF));
        return it;
    endfunction

    function automatic in_item_t make_write(input int slot, input int id, input int w,
                                            input int lim);
        in_item_t it;
        it = rand_item(OP_WRITE);
        it.entry_index = SLOT_W'(slot);
        it.entry_id    = ID_W'(id);
        it.weight      = WEIGHT_W'(w);
        it.use_limit   = LIMIT_W'(lim);
        return it;
    endfunction

    function automatic in_item_t make_draw(input int rv);
        in_item_t it;
        it = rand_item(OP_DRAW);
        it.random_value = RV_W'(rv);
        return it;
    endfunction

    // Favor small quotas so entries retire often, with edge weights mixed in.
    function automatic in_item_t rand_write();
        in_item_t    it;
        int unsigned roll;
        it = rand_item(OP_WRITE);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            it.weight = '0;
        else if (roll < 20)
            it.weight = WEIGHT_W'(WEIGHT_MAX);
        roll = $urandom_range(0, 99);
        if (roll < 15)
            it.use_limit = '0;
        else if (roll < 65)
            it.use_limit = LIMIT_W'($urandom_range(1, 3));
        else if (roll < 75)
            it.use_limit = '1;
        return it;
    endfunction

    function automatic in_item_t rand_draw();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return make_draw(0);
        if (roll < 20)
            return make_draw(16'hFFFF);
        return make_draw($urandom_range(0, 16'hFFFF));
    endfunction

    // Count only items the block acts on toward the random budget.
    task automatic stage_item(input in_item_t it, input bit counted);
        item_backlog = {item_backlog, it};
        if (counted && it.opcode != OP_UNUSED)
            random_sent++;
    endtask

    // One well-formed sequence: reload a few slots, restart, then draw until
    // quotas run dry; sprinkle in noise, late writes, extra restarts, and
    // now and then skip the restart altogether.
    task automatic run_deck();
        int          loads;
        int          draws;
        int unsigned roll;
        loads = $urandom_range(0, 4);
        repeat (loads)
            stage_item(rand_write(), 1'b1);
        if ($urandom_range(0, 9) != 0)
            stage_item(rand_item(OP_RESTART), 1'b1);
        draws = $urandom_range(4, 40);
        repeat (draws) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                stage_item(rand_item(OP_UNUSED), 1'b1);
            else if (roll < 12)
                stage_item(rand_write(), 1'b1);
            else if (roll < 15)
                stage_item(rand_item(OP_RESTART), 1'b1);
            else
                stage_item(rand_draw(), 1'b1);
        end
    endtask

    // Hold until every staged item went through and every result came back,
    // then let a restart that owes no result run out before going on.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (item_backlog.size() != 0 || in_valid || expected_picks.size() != 0);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    // Register write: one transfer on the configuration channel, only when idle.
    task automatic write_cfg(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        entries_cfg = value;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int cfg_plan [7] = '{16, 1, 31, 0, 2, 9, 16};
        int phase;
        int phase_start;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Register still at reset (zero): draws say nothing is configured,
        // opcode 3 is dropped, and a restart with no entries reads no slot.
        stage_item(make_draw(0), 1'b0);
        stage_item('1, 1'b0);
        stage_item(rand_item(OP_RESTART), 1'b0);
        // Load every slot once so that no later restart reads an empty one.
        // Slot 0: top weight, single use. Slot 1: zero weight, unlimited.
        // Slot 2: smallest weight, two uses. Slot 3: unlimited.
        stage_item(make_write(0, 0, WEIGHT_MAX, 1), 1'b0);
        stage_item(make_write(1, 255, 0, 0), 1'b0);
        stage_item(make_write(2, 8'hA5, 1, 2), 1'b0);
        stage_item(make_write(3, 8'h5A, 128, 0), 1'b0);
        for (int s = 4; s < SLOTS; s++)
            stage_item(make_write(s, $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 3)), 1'b0);
        stage_item(make_draw(16'hFFFF), 1'b0);
        wait_quiet();

        // Full table configured but no restart yet: the draw set is empty.
        write_cfg(CFG_W'(SLOTS));
        stage_item(make_draw(0), 1'b0);
        stage_item(rand_item(OP_RESTART), 1'b0);
        // Lowest pick takes slot 0, which retires at once; top pick takes the last span.
        stage_item(make_draw(0), 1'b0);
        stage_item(make_draw(16'hFFFF), 1'b0);
        // Rewrite slot 2 after the restart: the draw set must keep its old copy.
        stage_item(make_write(2, 8'h3C, 200, 1), 1'b0);
        stage_item(make_draw(0), 1'b0);
        stage_item(make_draw(0), 1'b0);

        // Random part: phases of decks, each phase under its own register value.
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_quiet();
            no_idle = ($urandom_range(0, 3) == 0);
            write_cfg(CFG_W'((phase < 7) ? cfg_plan[phase] : $urandom_range(0, SLOTS)));
            phase_start = random_sent;
            while (random_sent - phase_start < 110 && random_sent < RANDOM_ITEMS) begin
                run_deck();
                // Now and then hold the sender until the block has drained.
                if ($urandom_range(0, 4) == 0)
                    wait_quiet();
            end
            phase++;
        end

        no_idle = 1'b0;
        wait_quiet();
        if (fault_count == 0 && expected_picks.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
